/* rtl/core/assert_macros.svh */
// Assertion macros shared by the codec RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/z85rc_pkg.sv */
// Constants, types and helper functions of the rotating Z85 codec.
package z85rc_pkg;

    localparam int unsigned DIGITS = 5;
    localparam logic [6:0]  RADIX = 7'd85;
    localparam logic [6:0]  RADIX_M1 = 7'd84;
    // ceil(2^38 / 85): exact quotient for any 32-bit dividend
    localparam logic [31:0] RECIP = 32'd3233857729;
    localparam int unsigned RECIP_SHIFT = 38;

    localparam logic [8*85-1:0] ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_ROT_STEP = 1'b1;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [1:0] OP_QUOT = 2'd0;
    localparam logic [1:0] OP_REM = 2'd1;
    localparam logic [1:0] OP_MAC = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] digit;
    } char_digit_t;

    function automatic logic [7:0] digit_to_char(input logic [6:0] d);
        logic [9:0] pos;
        pos = {3'b000, 7'(RADIX_M1 - d)} << 3;
        return ALPHABET[pos +: 8];
    endfunction

    function automatic char_digit_t char_to_digit(input logic [7:0] c);
        char_digit_t res;
        res = '0;
        for (int i = 0; i < 85; i++)
        begin
            if (ALPHABET[8*(84-i) +: 8] == c)
            begin
                res.valid = 1'b1;
                res.digit = res.digit | 7'(i);
            end
        end
        return res;
    endfunction

    function automatic logic [6:0] add_mod(input logic [6:0] a, input logic [6:0] b);
        logic [7:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, RADIX})
        begin
            s = s - {1'b0, RADIX};
        end
        return s[6:0];
    endfunction

    function automatic logic [6:0] sub_mod(input logic [6:0] a, input logic [6:0] b);
        logic [6:0] r;
        if (a >= b)
        begin
            r = a - b;
        end
        else
        begin
            r = a + RADIX - b;
        end
        return r;
    endfunction

endpackage

/* rtl/core/z85rc_alu.sv */
// Shared arithmetic unit: divide by 85, remainder, multiply-accumulate by 85.
module z85rc_alu
    import z85rc_pkg::*;
(
    input  alu_req_t    req,
    output logic [31:0] y
);

    logic [63:0] prod;
    logic [31:0] sel;
    logic [31:0] times85;

    assign prod = 64'(req.a) * 64'(RECIP);
    assign sel = (req.op == OP_MAC) ? req.a : req.b;
    assign times85 = (sel << 6) + (sel << 4) + (sel << 2) + sel;

    always_comb
    begin
        unique case (req.op)
            OP_QUOT: y = 32'(prod >> RECIP_SHIFT);
            OP_REM:  y = req.a - times85;
            OP_MAC:  y = times85 + req.b;
            default: y = '0;
        endcase
    end

endmodule

/* rtl/core/z85_rotating_codec.sv */
// Rotating Z85 codec: sequencer, digit store and output register.
//
// Input channel (in_valid/in_ready): one request per 32-bit word (encode) or
// five characters (decode). Output channel (out_valid/out_ready): encode gives
// five character results, the fifth with last set; decode gives one word
// result with last set. Registers mode and rot_step are written through
// cfg_write_en/cfg_index/cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce this.
// Encode: quotient and remainder steps through the shared divide-by-85 unit
// split the word, one digit per step pair, then one character per cycle while
// the receiver accepts.
// Decode: multiply-accumulate steps through the same unit, one per character,
// then the result is loaded into the output register.
// in_ready is high only while the sequencer is idle; one request at a time.
// A stalled receiver holds the output register and the sequencer waits in its
// emit state; a new request is taken once the last result sits in the output
// register. Reset clears the sequencer, output valid, registers and offset.
`include "assert_macros.svh"

module z85_rotating_codec
    import z85rc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [39:0] data_in,
    input  logic        first_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic [31:0] out_word,
    output logic        bad_char,
    output logic        last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_QUOT = 3'd1;
    localparam logic [2:0] S_REM = 3'd2;
    localparam logic [2:0] S_DEC = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        mode_reg;
    logic [6:0]  step_reg;
    logic [6:0]  offset_reg, offset_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] word_reg;
    logic [31:0] q_reg;
    logic [39:0] data_reg;
    logic [31:0] acc_reg;
    logic        bad_reg;
    logic [6:0]  digits_reg [DIGITS];

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic [31:0] out_word_reg;
    logic        bad_char_reg;
    logic        last_reg;

    alu_req_t    alu_req;
    logic [31:0] alu_y;
    char_digit_t dec_digit;
    logic [6:0]  dec_rot;
    logic [6:0]  step_in;
    logic        in_req;
    logic        out_free;
    logic        emit_fire;

    z85rc_alu u_alu
    (
        .req (alu_req),
        .y   (alu_y)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_req = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;

    assign step_in = (cfg_data >= RADIX) ? (cfg_data - RADIX) : cfg_data;

    assign dec_digit = char_to_digit(data_reg[39:32]);
    assign dec_rot = add_mod(dec_digit.digit, offset_reg);

    always_comb
    begin
        alu_req.op = OP_QUOT;
        alu_req.a = word_reg;
        alu_req.b = q_reg;
        unique case (state_reg)
            S_REM:
            begin
                alu_req.op = OP_REM;
            end
            S_DEC:
            begin
                alu_req.op = OP_MAC;
                alu_req.a = acc_reg;
                alu_req.b = {25'b0, dec_rot};
            end
            default:
            begin
                alu_req.op = OP_QUOT;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        offset_next = offset_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    if (first_of_stream)
                    begin
                        offset_next = '0;
                    end
                    if (mode_reg == MODE_DECODE)
                    begin
                        state_next = S_DEC;
                        cnt_next = '0;
                    end
                    else
                    begin
                        state_next = S_QUOT;
                        cnt_next = 3'(DIGITS - 1);
                    end
                end
            end
            S_QUOT:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_QUOT;
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            S_DEC:
            begin
                offset_next = add_mod(offset_reg, step_reg);
                if (cnt_reg == 3'(DIGITS - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (mode_reg == MODE_DECODE || cnt_reg == 3'(DIGITS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                    if (mode_reg == MODE_ENCODE)
                    begin
                        offset_next = add_mod(offset_reg, step_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            offset_reg <= '0;
            mode_reg <= MODE_ENCODE;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            offset_reg <= offset_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_MODE:     mode_reg <= cfg_data[0];
                    REG_ROT_STEP: step_reg <= step_in;
                    default:      mode_reg <= mode_reg;
                endcase
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    word_reg <= data_in[31:0];
                    data_reg <= data_in;
                    acc_reg <= '0;
                    bad_reg <= 1'b0;
                end
            end
            S_QUOT:
            begin
                q_reg <= alu_y;
            end
            S_REM:
            begin
                digits_reg[cnt_reg] <= alu_y[6:0];
                word_reg <= q_reg;
            end
            S_DEC:
            begin
                acc_reg <= alu_y;
                bad_reg <= bad_reg || !dec_digit.valid;
                data_reg <= data_reg << 8;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
        if (emit_fire)
        begin
            if (mode_reg == MODE_DECODE)
            begin
                out_char_reg <= '0;
                out_word_reg <= acc_reg;
                bad_char_reg <= bad_reg;
                last_reg <= 1'b1;
            end
            else
            begin
                out_char_reg <= digit_to_char(sub_mod(digits_reg[cnt_reg], offset_reg));
                out_word_reg <= '0;
                bad_char_reg <= 1'b0;
                last_reg <= (cnt_reg == 3'(DIGITS - 1));
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char = out_char_reg;
    assign out_word = out_word_reg;
    assign bad_char = bad_char_reg;
    assign last = last_reg;

    `ASSERT_ALWAYS(a_offset_range, (offset_reg < RADIX) && (step_reg < RADIX), "offset or step out of range")
    `ASSERT_IMPLY(a_rem_digit, state_reg == S_REM, alu_y < 32'(RADIX), "remainder not a base-85 digit")
    `ASSERT_NEXT(a_req_starts, in_req, state_reg != S_IDLE, "request did not start the sequencer")
    `ASSERT_NEXT(a_last_idle, emit_fire && (cnt_reg == 3'(DIGITS - 1) || mode_reg == MODE_DECODE), (state_reg == S_IDLE) && last_reg, "final result not marked last")

endmodule
